// File: rtl/pal_pkg.sv
// ----------------------------------------------------------------------------
// pal_pkg
// Shared constants, codes and types for the positional array list block.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

    // list geometry
    localparam int CAPACITY   = 64;
    localparam int ELEM_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // fixed port widths
    localparam int ACTION_W = 2;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // width used to compare a position against the entry count
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_SHIFT_LAST,
        S_WRITE_VAL,
        S_READ,
        S_READ_WAIT,
        S_FINISH
    } state_t;

    // one write port and one read port of the list memory
    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [ELEM_WIDTH-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } mem_req_t;

    // finished result of one item
    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/pal_ram.sv
// ----------------------------------------------------------------------------
// pal_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/pal_seq.sv
// ----------------------------------------------------------------------------
// pal_seq
// Request sequencer: checks each item against the entry count, walks the
// list memory for the insert and delete shifts, and builds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_seq (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire pal_pkg::action_t          in_action,
    input  wire logic [pal_pkg::POS_W-1:0] in_position,
    input  wire logic [pal_pkg::VALUE_W-1:0] in_value,
    output pal_pkg::mem_req_t              mem_req,
    input  wire logic [pal_pkg::ELEM_WIDTH-1:0] mem_rdata,
    output logic                           res_valid,
    input  wire logic                      res_ready,
    output pal_pkg::result_t               res
);

    import pal_pkg::*;

    state_t                state_reg, state_next;
    action_t               act_reg;
    status_t               status_reg;
    logic [ADDR_W-1:0]     slot_reg;
    logic [ELEM_WIDTH-1:0] val_reg;
    logic [ADDR_W-1:0]     ptr_reg;
    logic [ADDR_W-1:0]     end_reg;
    logic [ADDR_W-1:0]     waddr_reg;
    logic                  pend_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [ELEM_WIDTH-1:0] rdval_reg;

    logic                  accept;
    logic                  pos_ok;
    logic                  full;
    logic [ADDR_W-1:0]     dec_slot;
    logic [CNT_W-1:0]      cnt_last;
    status_t               dec_status;
    logic                  del_tail;
    logic                  changes;
    logic [CNT_W-1:0]      cnt_new;

    assign accept = in_valid && in_ready;

    // request checks against the current count
    always_comb begin
        pos_ok   = (CMP_W'(in_position) != CMP_W'(0))
                && (CMP_W'(in_position) <= CMP_W'(cnt_reg));
        full     = (cnt_reg == CNT_W'(CAPACITY));
        dec_slot = ADDR_W'(CMP_W'(in_position) - CMP_W'(1));
        cnt_last = cnt_reg - CNT_W'(1);
        del_tail = (CNT_W'(dec_slot) == cnt_last);
        case (in_action)
            ACT_APPEND: dec_status = full ? ST_FULL : ST_OK;
            ACT_INSERT: dec_status = !pos_ok ? ST_RANGE : (full ? ST_FULL : ST_OK);
            default:    dec_status = !pos_ok ? ST_RANGE : ST_OK;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (dec_status != ST_OK) begin
                        state_next = S_FINISH;
                    end else begin
                        case (in_action)
                            ACT_APPEND: state_next = S_WRITE_VAL;
                            ACT_INSERT: state_next = S_SHIFT;
                            ACT_DELETE: state_next = del_tail ? S_FINISH : S_SHIFT;
                            default:    state_next = S_READ;
                        endcase
                    end
                end
            end
            S_SHIFT: begin
                if (ptr_reg == end_reg) begin
                    state_next = S_SHIFT_LAST;
                end
            end
            S_SHIFT_LAST: begin
                state_next = (act_reg == ACT_INSERT) ? S_WRITE_VAL : S_FINISH;
            end
            S_WRITE_VAL: state_next = S_FINISH;
            S_READ:      state_next = S_READ_WAIT;
            S_READ_WAIT: state_next = S_FINISH;
            S_FINISH: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs: handshake and memory port
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mem_req   = '0;
        unique case (state_reg)
            S_IDLE: in_ready = 1'b1;
            S_SHIFT: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ptr_reg;
                mem_req.we    = pend_reg;
                mem_req.waddr = waddr_reg;
                mem_req.wdata = mem_rdata;
            end
            S_SHIFT_LAST: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = waddr_reg;
                mem_req.wdata = mem_rdata;
            end
            S_WRITE_VAL: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = slot_reg;
                mem_req.wdata = val_reg;
            end
            S_READ: begin
                mem_req.re    = 1'b1;
                mem_req.raddr = slot_reg;
            end
            S_READ_WAIT: ;
            S_FINISH: res_valid = 1'b1;
            default: ;
        endcase
    end

    // count after this item
    always_comb begin
        changes = (status_reg == ST_OK);
        case (act_reg)
            ACT_APPEND, ACT_INSERT: cnt_new = changes ? cnt_reg + CNT_W'(1) : cnt_reg;
            ACT_DELETE:             cnt_new = changes ? cnt_reg - CNT_W'(1) : cnt_reg;
            default:                cnt_new = cnt_reg;
        endcase
        res.read_value = (act_reg == ACT_READ && changes) ? VALUE_W'(rdval_reg)
                                                          : VALUE_W'(0);
        res.status     = status_reg;
        res.count      = COUNT_W'(cnt_new);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == S_SHIFT);
            if (res_valid && res_ready) begin
                cnt_reg <= cnt_new;
            end
        end
    end

    // item fields and shift pointers
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg    <= in_action;
            status_reg <= dec_status;
            val_reg    <= ELEM_WIDTH'(in_value);
            slot_reg   <= (in_action == ACT_APPEND) ? ADDR_W'(cnt_reg) : dec_slot;
            if (in_action == ACT_INSERT) begin
                ptr_reg <= ADDR_W'(cnt_last);
                end_reg <= dec_slot;
            end else begin
                ptr_reg <= dec_slot + ADDR_W'(1);
                end_reg <= ADDR_W'(cnt_last);
            end
        end else if (state_reg == S_SHIFT) begin
            if (act_reg == ACT_INSERT) begin
                ptr_reg   <= ptr_reg - ADDR_W'(1);
                waddr_reg <= ptr_reg + ADDR_W'(1);
            end else begin
                ptr_reg   <= ptr_reg + ADDR_W'(1);
                waddr_reg <= ptr_reg - ADDR_W'(1);
            end
        end
        if (state_reg == S_READ_WAIT) begin
            rdval_reg <= mem_rdata;
        end
    end

    // the count stays within the capacity
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // a shift never reads the entry it writes in the same cycle
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
        else $error("shift read and write hit the same entry");

    // the count moves only when a result is handed over
    a_cnt_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != $past(cnt_reg)) |-> $past(res_valid && res_ready))
        else $error("count changed without a result");

    // a shift write always follows a read of the previous cycle
    a_shift_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT_LAST) |-> $past(state_reg == S_SHIFT))
        else $error("shift tail without a pending read");

endmodule

`default_nettype wire

// File: rtl/positional_array_list_top.sv
// ----------------------------------------------------------------------------
// positional_array_list_top
// Ordered list in a fixed store with append, insert, delete and read by
// 1-based position; every item returns value, status and entry count.
//
//   channel  dir  ports                                   handshake
//   s_       in   s_action, s_position, s_value           s_valid / s_ready
//   m_       out  m_read_value, m_status, m_count         m_valid / m_ready
//
// append writes the value, read reads one entry, a failed request only returns
// its result; delete (unless of the last entry) and insert shift the entries
// behind the position, walking the list memory one entry per cycle.
// reset clears count, state and output valid, never the list memory.
// a new item is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [pal_pkg::ACTION_W-1:0]  s_action,
    input  wire logic [pal_pkg::POS_W-1:0]     s_position,
    input  wire logic [pal_pkg::VALUE_W-1:0]   s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [pal_pkg::VALUE_W-1:0]   m_read_value,
    output logic      [pal_pkg::STATUS_W-1:0]  m_status,
    output logic      [pal_pkg::COUNT_W-1:0]   m_count
);

    import pal_pkg::*;

    mem_req_t              mem_req;
    logic [ELEM_WIDTH-1:0] mem_rdata;
    logic                  res_valid;
    logic                  res_ready;
    result_t               res;
    logic                  m_valid_reg;
    result_t               out_reg;

    // sequencer
    pal_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_action   (action_t'(s_action)),
        .in_position (s_position),
        .in_value    (s_value),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // list memory
    pal_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ELEM_WIDTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // output register
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = out_reg.read_value;
    assign m_status     = out_reg.status;
    assign m_count      = out_reg.count;

endmodule

`default_nettype wire
